// ===== rtl/oee_pkg.sv =====
// Shared types and codes for the oldest-entry eviction block.
// Used by oee_cell and oldest_entry_eviction_top; no dependencies.
package oee_pkg;

  // item opcodes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EVICT   = 2'd1;
  localparam logic [1:0] OP_SET_MEM = 2'd2;

  // configuration register indexes
  localparam logic REG_AGE_CEILING    = 1'b0;
  localparam logic REG_ENTRIES_IN_USE = 1'b1;

  // highest count the scan can cover; victims always index below this
  localparam int SCAN_LIMIT = 256;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // entry write broadcast to every cell (stamp travels beside it)
  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [15:0] lock;
    logic        pinned;
    logic        present;
    logic [31:0] size;
  } wr_cmd_t;

  // present-bit clear for the chosen victim
  typedef struct packed {
    logic       en;
    logic [7:0] index;
  } clr_cmd_t;

  // scan token handed from cell to cell (best stamp travels beside it)
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [7:0]  win;
    logic [31:0] size;
  } scan_tok_t;

endpackage

// ===== rtl/oldest_entry_eviction_top.sv =====
// Top level of the oldest-entry eviction block: controller and cell row.
// Depends on oee_pkg and oee_cell.
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  in       | in_valid/in_ready, opcode .. memory_value       | input item
//  out      | out_valid/out_ready, evicted .. used_memory     | result item
//  cfg      | cfg_we, cfg_index, cfg_data                     | register write
//
// An evict item sends the scan token along the cell row one cell a cycle,
// then the victim is cleared and the counter updated. One item is in flight
// at a time; a new item is taken once the previous result has been or is
// being taken. rst is synchronous; it clears present bits, the counter and
// the registers to their defaults.
module oldest_entry_eviction_top
  import oee_pkg::*;
#(
  parameter int ENTRIES    = 256,
  parameter int STAMP_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [7:0]         entry_index,
  input  logic [31:0]        stamp,
  input  logic signed [15:0] lock_count,
  input  logic               pinned,
  input  logic               present,
  input  logic [31:0]        entry_size,
  input  logic signed [31:0] memory_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               evicted,
  output logic [7:0]         victim_index,
  output logic [31:0]        victim_size,
  output logic signed [31:0] used_memory,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  state_t                state;
  logic [STAMP_BITS-1:0] age_ceiling;
  logic [8:0]            entries_in_use;
  logic signed [31:0]    mem_counter;

  logic [63:0]           stamp_wide;
  logic [63:0]           ceil_wide;
  logic                  accept;
  logic                  scan_done;
  wr_cmd_t               wr;
  clr_cmd_t              clr;

  scan_tok_t             tok  [ENTRIES+1];
  logic [STAMP_BITS-1:0] best [ENTRIES+1];

  assign stamp_wide = {32'd0, stamp};
  assign ceil_wide  = {32'd0, cfg_data};

  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign scan_done = tok[ENTRIES].valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      age_ceiling    <= STAMP_BITS'(64'hFFFF_FFFF);
      entries_in_use <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AGE_CEILING:    age_ceiling    <= ceil_wide[STAMP_BITS-1:0];
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[8:0];
        default:            ;
      endcase
    end
  end

  // entry write broadcast
  always_comb begin
    wr.en      = accept && (opcode == OP_WRITE) && (32'(entry_index) < ENTRIES);
    wr.index   = entry_index;
    wr.lock    = lock_count;
    wr.pinned  = pinned;
    wr.present = present;
    wr.size    = entry_size;
  end

  // scan token enters at cell 0 with the ceiling as best stamp
  always_comb begin
    tok[0].valid = accept && (opcode == OP_EVICT);
    tok[0].found = 1'b0;
    tok[0].win   = 8'd0;
    tok[0].size  = 32'd0;
    best[0]      = age_ceiling;
  end

  // victim present-bit clear at the end of the scan
  assign clr.en    = scan_done && tok[ENTRIES].found;
  assign clr.index = tok[ENTRIES].win;

  // row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    oee_cell #(
      .IDX        (i),
      .STAMP_BITS (STAMP_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr),
      .wr_stamp (stamp_wide[STAMP_BITS-1:0]),
      .clr      (clr),
      .count    (entries_in_use),
      .tok_in   (tok[i]),
      .best_in  (best[i]),
      .tok_out  (tok[i+1]),
      .best_out (best[i+1])
    );
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept && (opcode == OP_EVICT)) state <= ST_SCAN;
        ST_SCAN: if (scan_done) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // used-memory counter
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_counter <= 32'sd0;
    end else if (accept && (opcode == OP_SET_MEM)) begin
      mem_counter <= memory_value;
    end else if (clr.en) begin
      mem_counter <= mem_counter - $signed(tok[ENTRIES].size);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (opcode != OP_EVICT)) || scan_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (scan_done) begin
      evicted      <= tok[ENTRIES].found;
      victim_index <= tok[ENTRIES].found ? tok[ENTRIES].win : 8'd0;
      victim_size  <= tok[ENTRIES].found ? tok[ENTRIES].size : 32'd0;
      used_memory  <= tok[ENTRIES].found ? mem_counter - $signed(tok[ENTRIES].size)
                                         : mem_counter;
    end else if (accept && (opcode != OP_EVICT)) begin
      evicted      <= 1'b0;
      victim_index <= 8'd0;
      victim_size  <= 32'd0;
      used_memory  <= (opcode == OP_SET_MEM) ? memory_value : mem_counter;
    end
  end

`ifndef SYNTH
  // an evict item holds off new items while the token is in the row
  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_EVICT)) |=> ((state == ST_SCAN) && !in_ready))
    else $error("evict item did not enter the scan state");

  // a token only leaves the row while a scan is pending
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == ST_SCAN))
    else $error("scan token left the row outside a scan");

  // a found victim is reported and is never entry zero
  a_victim_report: assert property (@(posedge clk) disable iff (rst)
    (scan_done && tok[ENTRIES].found) |=> (out_valid && evicted && (victim_index != 8'd0)))
    else $error("victim missing from result");

  // a pending result carries the current counter
  a_counter_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (used_memory == mem_counter))
    else $error("result counter differs from used-memory counter");
`endif

endmodule

// ===== rtl/oee_cell.sv =====
// One table entry plus one hop of the eviction scan.
// Depends on oee_pkg for the write, clear and token structs.
module oee_cell
  import oee_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int STAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wr_cmd_t               wr,
  input  logic [STAMP_BITS-1:0] wr_stamp,
  input  clr_cmd_t              clr,
  input  logic [8:0]            count,
  input  scan_tok_t             tok_in,
  input  logic [STAMP_BITS-1:0] best_in,
  output scan_tok_t             tok_out,
  output logic [STAMP_BITS-1:0] best_out
);

  // only cells below the scan limit are addressable or scanned
  localparam bit         ADDR_OK  = (IDX < SCAN_LIMIT);
  localparam bit         SCOPE_OK = (IDX >= 1) && (IDX < SCAN_LIMIT);
  localparam logic [7:0] IDX8     = 8'(IDX);
  localparam logic [8:0] IDX9     = 9'(IDX);

  logic [STAMP_BITS-1:0] stamp;
  logic [15:0]           lock;
  logic                  pinned;
  logic                  present;
  logic [31:0]           size;

  logic wr_hit;
  logic clr_hit;
  logic unlocked;
  logic elig;

  assign wr_hit   = ADDR_OK && wr.en && (wr.index == IDX8);
  assign clr_hit  = ADDR_OK && clr.en && (clr.index == IDX8);
  assign unlocked = (lock == 16'd0) || lock[15];

  // entry can beat the best candidate seen so far
  assign elig = SCOPE_OK && (IDX9 < count) && present && !pinned && unlocked &&
                (size != 32'd0) && (stamp < best_in);

  // entry payload
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      stamp  <= wr_stamp;
      lock   <= wr.lock;
      pinned <= wr.pinned;
      size   <= wr.size;
    end
  end

  // present bit, cleared at reset and on eviction
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
    end else if (wr_hit) begin
      present <= wr.present;
    end else if (clr_hit) begin
      present <= 1'b0;
    end
  end

  // token valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  // token payload: take over the candidate or pass it on
  always_ff @(posedge clk) begin
    if (tok_in.valid && elig) begin
      tok_out.found <= 1'b1;
      tok_out.win   <= IDX8;
      tok_out.size  <= size;
      best_out      <= stamp;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.win   <= tok_in.win;
      tok_out.size  <= tok_in.size;
      best_out      <= best_in;
    end
  end

endmodule

// ===== dv/oldest_entry_eviction_top_tb.sv =====
// Self-checking testbench for oldest_entry_eviction_top: directed entry and eviction
// cases, then random phases over several register settings with random stalls on both sides.
// Depends on oee_pkg and the oldest_entry_eviction_top RTL.
module oldest_entry_eviction_top_tb;
  import oee_pkg::*;

  // opcode with no meaning, answered like a write
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         NUM_SLOTS  = 256;
  localparam int         IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [31:0] stamp;
    logic [15:0] lock;
    logic        pin;
    logic        pres;
    logic [31:0] size;
    logic [31:0] mem;
  } req_t;

  typedef struct packed {
    logic        evicted;
    logic [7:0]  idx;
    logic [31:0] size;
    logic [31:0] used;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = '0;
  logic [7:0]         entry_index = '0;
  logic [31:0]        stamp = '0;
  logic signed [15:0] lock_count = '0;
  logic               pinned = 1'b0;
  logic               present = 1'b0;
  logic [31:0]        entry_size = '0;
  logic signed [31:0] memory_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               evicted;
  logic [7:0]         victim_index;
  logic [31:0]        victim_size;
  logic signed [31:0] used_memory;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [31:0]        cfg_data = '0;

  // predicted table contents and registers
  logic [31:0] slot_stamp   [NUM_SLOTS];
  logic [15:0] slot_lock    [NUM_SLOTS];
  logic        slot_pinned  [NUM_SLOTS];
  logic        slot_present [NUM_SLOTS];
  logic [31:0] slot_size    [NUM_SLOTS];
  logic [31:0] mem_counter;
  logic [31:0] ceiling_reg;
  logic [8:0]  count_reg;

  // slots that some queued write has loaded, so a scan never reads an unwritten one
  bit          slot_loaded  [NUM_SLOTS];

  req_t     req_q[$];
  outcome_t outcome_q[$];
  int       errors = 0;

  always #1 clk = ~clk;

  oldest_entry_eviction_top dut (.*);

  // apply one accepted item to the predicted table and queue its result
  task automatic apply_to_table(input req_t r);
    outcome_t    o;
    int          lim;
    logic [31:0] best;
    logic        hit;
    logic [7:0]  win;
    o = '0;
    case (r.op)
      OP_WRITE: begin
        slot_stamp[r.idx]   = r.stamp;
        slot_lock[r.idx]    = r.lock;
        slot_pinned[r.idx]  = r.pin;
        slot_present[r.idx] = r.pres;
        slot_size[r.idx]    = r.size;
      end
      OP_EVICT: begin
        lim = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
        best = ceiling_reg;
        hit = 1'b0;
        win = '0;
        // strict compare keeps the earlier slot on equal stamps
        for (int i = 1; i < lim; i++) begin
          if (slot_stamp[i] < best && $signed(slot_lock[i]) <= 16'sd0 && !slot_pinned[i] &&
              slot_present[i] && slot_size[i] != 32'd0) begin
            hit = 1'b1;
            win = 8'(i);
            best = slot_stamp[i];
          end
        end
        if (hit) begin
          o.evicted = 1'b1;
          o.idx = win;
          o.size = slot_size[win];
          mem_counter = mem_counter - slot_size[win];
          slot_present[win] = 1'b0;
        end
      end
      OP_SET_MEM: begin
        mem_counter = r.mem;
      end
      default: begin
      end
    endcase
    o.used = mem_counter;
    outcome_q.push_back(o);
  endtask

  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(0, 7))
      0: pick_stamp = $urandom_range(0, 15);
      1: pick_stamp = ceiling_reg - 32'd1;
      2: pick_stamp = ceiling_reg;
      3: pick_stamp = ceiling_reg + 32'd1;
      4: pick_stamp = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      default: pick_stamp = $urandom();
    endcase
  endfunction

  // mostly unlocked so that evictions keep finding victims
  function automatic logic [15:0] pick_lock();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: pick_lock = 16'h0000;
      4, 5: pick_lock = 16'(16'h8000 | $urandom_range(0, 16'h7FFF));
      6: pick_lock = 16'($urandom_range(1, 16'h7FFF));
      default: pick_lock = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 7))
      0: pick_size = 32'h0;
      1: pick_size = 32'hFFFF_FFFF;
      2, 3: pick_size = $urandom_range(1, 255);
      default: pick_size = $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_mem();
    case ($urandom_range(0, 3))
      0: pick_mem = 32'h8000_0000;
      1: pick_mem = 32'h7FFF_FFFF;
      default: pick_mem = $urandom();
    endcase
  endfunction

  function automatic req_t write_req(input logic [7:0] idx, input logic [31:0] stp,
                                     input logic [15:0] lock, input logic pin,
                                     input logic pres, input logic [31:0] size);
    req_t r;
    r.op = OP_WRITE;
    r.idx = idx;
    r.stamp = stp;
    r.lock = lock;
    r.pin = pin;
    r.pres = pres;
    r.size = size;
    r.mem = $urandom();
    return r;
  endfunction

  // non-write item; the entry fields carry junk that must be ignored
  function automatic req_t ctl_req(input logic [1:0] op, input logic [31:0] mem);
    req_t r;
    r = write_req(8'($urandom()), $urandom(), 16'($urandom()), 1'($urandom()),
                  1'($urandom()), $urandom());
    r.op = op;
    r.mem = mem;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    int   lim;
    int   hole;
    r = write_req(8'($urandom()), pick_stamp(), pick_lock(), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 7) != 0, pick_size());
    r.mem = pick_mem();
    pick = $urandom_range(0, 19);
    if (pick >= 11 && pick <= 16) r.op = OP_EVICT;
    else if (pick >= 17 && pick <= 18) r.op = OP_SET_MEM;
    else if (pick == 19) r.op = OP_UNUSED;
    // an evict may only scan loaded slots; fill the first hole instead
    if (r.op == OP_EVICT) begin
      lim = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
      hole = 0;
      for (int i = lim - 1; i >= 1; i--) begin
        if (!slot_loaded[i]) hole = i;
      end
      if (hole > 0) begin
        r.op = OP_WRITE;
        r.idx = 8'(hole);
      end
    end
    return r;
  endfunction

  task automatic queue_item(input req_t r);
    if (r.op == OP_WRITE) slot_loaded[r.idx] = 1'b1;
    req_q.push_back(r);
  endtask

  // settled values are sampled on the falling edge
  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  // register writes only while the block is idle
  task automatic reconfigure(input logic [31:0] ceil, input logic [31:0] cnt_word);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_AGE_CEILING;
    cfg_data <= ceil;
    @(posedge clk);
    cfg_index <= REG_ENTRIES_IN_USE;
    cfg_data <= cnt_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    ceiling_reg = ceil;
    count_reg = cnt_word[8:0];
  endtask

  // input driver: one item at a time with random gaps between items
  req_t drv_req;
  int   gap_left = 0;
  bit   drv_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_to_table(drv_req);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          drv_req = req_q.pop_front();
          opcode <= drv_req.op;
          entry_index <= drv_req.idx;
          stamp <= drv_req.stamp;
          lock_count <= drv_req.lock;
          pinned <= drv_req.pin;
          present <= drv_req.pres;
          entry_size <= drv_req.size;
          memory_value <= drv_req.mem;
          in_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) drv_steady = !drv_steady;
          gap_left = drv_steady ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: stalls each result a random number of cycles and checks it
  int       hold_left = 0;
  bit       mon_steady = 1'b0;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: evicted=%0d index=%0d size=%h used=%h",
                     evicted, victim_index, victim_size, used_memory);
        end else begin
          want = outcome_q.pop_front();
          if (evicted !== want.evicted || victim_index !== want.idx ||
              victim_size !== want.size || used_memory !== want.used) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: got %0d/%0d/%h/%h, expected %0d/%0d/%h/%h",
                       evicted, victim_index, victim_size, used_memory,
                       want.evicted, want.idx, want.size, want.used);
          end
        end
        if ($urandom_range(0, 31) == 0) mon_steady = !mon_steady;
        hold_left = mon_steady ? 0 : $urandom_range(0, 7);
      end else if (out_valid && hold_left > 0) begin
        hold_left = hold_left - 1;
      end
      out_ready <= (hold_left == 0);
    end
  end

  // watchdog on cycles with no item moving on either channel
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  logic [31:0] ph_ceil;
  logic [31:0] ph_count;
  int          ph_items;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_stamp[i] = '0;
      slot_lock[i] = '0;
      slot_pinned[i] = 1'b0;
      slot_present[i] = 1'b0;
      slot_size[i] = '0;
      slot_loaded[i] = 1'b0;
    end
    mem_counter = '0;
    ceiling_reg = 32'hFFFF_FFFF;
    count_reg = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: empty scan, counter extremes, unused opcode
    queue_item(ctl_req(OP_EVICT, $urandom()));
    queue_item(ctl_req(OP_SET_MEM, 32'h7FFF_FFFF));
    queue_item(ctl_req(OP_SET_MEM, 32'h8000_0000));
    queue_item(ctl_req(OP_UNUSED, $urandom()));
    // slot 0 looks eligible but is never scanned
    queue_item(write_req(8'd0, 32'h0, 16'h0000, 1'b0, 1'b1, 32'd5));
    queue_item(write_req(8'd255, 32'hFFFF_FFFF, 16'h7FFF, 1'b1, 1'b1, 32'hFFFF_FFFF));

    // a count of one scans nothing
    reconfigure(32'hFFFF_FFFF, 32'd1);
    queue_item(ctl_req(OP_EVICT, $urandom()));
    // locked, pinned, absent and empty slots, then a tie on equal stamps
    queue_item(write_req(8'd1, 32'd10, 16'h0001, 1'b0, 1'b1, 32'd100));
    queue_item(write_req(8'd2, 32'd20, 16'h0000, 1'b1, 1'b1, 32'd50));
    queue_item(write_req(8'd3, 32'd5, 16'h0000, 1'b0, 1'b0, 32'd60));
    queue_item(write_req(8'd4, 32'd3, 16'h0000, 1'b0, 1'b1, 32'd0));
    queue_item(write_req(8'd5, 32'd30, 16'h8000, 1'b0, 1'b1, 32'd7));
    queue_item(write_req(8'd6, 32'd30, 16'hFFFF, 1'b0, 1'b1, 32'hFFFF_FFFF));

    // counter wraps on the first of the evictions, then nothing is left
    reconfigure(32'hFFFF_FFFF, 32'd7);
    queue_item(ctl_req(OP_EVICT, $urandom()));
    queue_item(ctl_req(OP_EVICT, $urandom()));
    queue_item(ctl_req(OP_EVICT, $urandom()));
    queue_item(write_req(8'd1, 32'd10, 16'h0000, 1'b0, 1'b1, 32'd1));

    // stamp equal to the ceiling is not old enough
    reconfigure(32'd10, 32'd7);
    queue_item(ctl_req(OP_EVICT, $urandom()));
    queue_item(ctl_req(OP_SET_MEM, 32'h0));
    queue_item(write_req(8'd2, 32'd9, 16'h0000, 1'b0, 1'b1, 32'd2));
    queue_item(ctl_req(OP_EVICT, $urandom()));
    queue_item(ctl_req(OP_SET_MEM, 32'hFFFF_FFFF));

    // full table: load every slot but slot 0, then random traffic
    reconfigure(32'hFFFF_FFFF, ($urandom() << 9) | 32'd256);
    for (int i = 1; i < NUM_SLOTS; i++) begin
      queue_item(write_req(8'(i), pick_stamp(), pick_lock(), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 7) != 0, pick_size()));
    end
    repeat (300) queue_item(random_req());

    // further register settings, extremes among them
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          ph_ceil = $urandom();
          ph_count = $urandom_range(2, 255);
          ph_items = 300;
        end
        2: begin
          ph_ceil = 32'h0;
          ph_count = 32'd511;
          ph_items = 200;
        end
        3: begin
          ph_ceil = 32'h8000_0000;
          ph_count = 32'd257;
          ph_items = 300;
        end
        4: begin
          ph_ceil = 32'd16;
          ph_count = 32'd3;
          ph_items = 150;
        end
        default: begin
          ph_ceil = $urandom();
          ph_count = 32'd256;
          ph_items = 250;
        end
      endcase
      reconfigure(ph_ceil, ($urandom() << 9) | ph_count);
      repeat (ph_items) queue_item(random_req());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
